[rtl/tsd_pkg.sv]
package tsd_pkg;

	// sizes of the readout format
	localparam int PORT_COUNT   = 4;
	localparam int MODULE_COUNT = 16;
	localparam int MEMORY_COUNT = 4;

	localparam int WORD_W     = 32;
	localparam int PORT_IN_W  = 8;
	localparam int PORT_W     = 2;
	localparam int MOD_W      = 4;
	localparam int MEM_W      = 2;
	localparam int MODCNT_W   = 5;
	localparam int CNT_W      = 30;
	localparam int CFG_IDX_W  = 8;

	// header nibbles
	localparam logic [3:0] HDR_HLEN = 4'h3;
	localparam logic [3:0] HDR_DLEN = 4'h4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODULES_ON_PORT0 = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_REG_COUNT        = CFG_IDX_W'(PORT_COUNT);

	typedef logic [PORT_COUNT-1:0][MODCNT_W-1:0] modcnt_arr_t;

	// reset module counts, port 0 in the low element
	localparam modcnt_arr_t MODCNT_RESET = modcnt_arr_t'({5'd2, 5'd2, 5'd2, 5'd4});

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_SIZE   = 2'd1,
		PH_DATA   = 2'd2,
		PH_ENDED  = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_FRAMING    = 3'd0,
		ST_DATA       = 3'd1,
		ST_BAD_HEADER = 3'd2,
		ST_ZERO_SIZE  = 3'd3,
		ST_CLAMPED    = 3'd4,
		ST_IGNORED    = 3'd5,
		ST_BAD_PORT   = 3'd6
	} status_t;

	typedef struct packed {
		status_t           status;
		logic [WORD_W-1:0] data_word;
		logic [PORT_W-1:0] port_tag;
		logic [MOD_W-1:0]  module_tag;
		logic [MEM_W-1:0]  memory_tag;
	} result_t;

endpackage

[rtl/tsd_cfg_regs.sv]
module tsd_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tsd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tsd_pkg::MODCNT_W-1:0]      cfg_data,
	output tsd_pkg::modcnt_arr_t              modcnt
);

	tsd_pkg::modcnt_arr_t modcnt_q;

	// writes are always taken, indexes past the list are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modcnt_q <= tsd_pkg::MODCNT_RESET;
		end else if (cfg_valid && (cfg_index < tsd_pkg::CFG_REG_COUNT)) begin
			modcnt_q[tsd_pkg::PORT_W'(cfg_index - tsd_pkg::CFG_MODULES_ON_PORT0)] <= cfg_data;
		end
	end

	assign modcnt = modcnt_q;

endmodule

[rtl/tsd_parser.sv]
module tsd_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [tsd_pkg::WORD_W-1:0]        word_in,
	input  logic [tsd_pkg::PORT_IN_W-1:0]     port_in,
	input  logic                              subevent_start,
	input  logic                              event_start,
	input  tsd_pkg::modcnt_arr_t              modcnt,
	input  logic                              res_room,
	output logic                              res_valid,
	output tsd_pkg::result_t                  res
);

	// input stage
	logic                          valid_s1;
	logic [tsd_pkg::WORD_W-1:0]    word_s1;
	logic [tsd_pkg::PORT_IN_W-1:0] port_s1;
	logic                          sub_s1;
	logic                          evt_s1;

	// parser state
	tsd_pkg::phase_t           phase_q, phase_n;
	logic [tsd_pkg::MOD_W-1:0] mod_q, mod_n;
	logic [tsd_pkg::MEM_W-1:0] mem_q, mem_n;
	logic [tsd_pkg::CNT_W-1:0] exp_q, exp_n;
	logic [tsd_pkg::CNT_W-1:0] seen_q, seen_n;
	logic                      halted_q, halted_n;

	// decoded view of the current word
	tsd_pkg::phase_t           phase_e;
	logic [tsd_pkg::MOD_W-1:0] mod_e;
	logic [tsd_pkg::MEM_W-1:0] mem_e;
	logic [tsd_pkg::CNT_W-1:0] exp_e;
	logic [tsd_pkg::CNT_W-1:0] seen_e;
	logic                      halt_e;
	logic                      port_ok;
	logic                      count_left;
	logic                      parse_hdr;
	logic                      hdr_ok;
	logic                      mem_bad;
	logic                      mod_bad;
	logic [tsd_pkg::MODCNT_W-1:0] mod_limit;
	logic [tsd_pkg::MOD_W-1:0] hdr_mod;
	logic [tsd_pkg::MEM_W-1:0] hdr_mem;
	logic                      adv;
	tsd_pkg::status_t          status_c;

	assign adv      = valid_s1 && res_room;
	assign in_ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= word_in;
			port_s1 <= port_in;
			sub_s1  <= subevent_start;
			evt_s1  <= event_start;
		end
	end

	// start flags, header fields, limits
	always_comb begin
		halt_e  = evt_s1 ? 1'b0 : halted_q;
		phase_e = phase_q;
		mod_e   = mod_q;
		mem_e   = mem_q;
		exp_e   = exp_q;
		seen_e  = seen_q;
		if (sub_s1) begin
			phase_e = tsd_pkg::PH_HEADER;
			mod_e   = '0;
			mem_e   = '0;
			exp_e   = '0;
			seen_e  = '0;
		end
		port_ok    = port_s1 < tsd_pkg::PORT_IN_W'(tsd_pkg::PORT_COUNT);
		count_left = seen_e < exp_e;
		parse_hdr  = (phase_e == tsd_pkg::PH_HEADER) ||
			((phase_e == tsd_pkg::PH_DATA) && !count_left);
		hdr_ok     = (word_s1[7:4] == tsd_pkg::HDR_HLEN) && (word_s1[3:0] == tsd_pkg::HDR_DLEN);
		// counts above the module total act as the total
		mod_limit  = modcnt[port_s1[tsd_pkg::PORT_W-1:0]];
		if (mod_limit > tsd_pkg::MODCNT_W'(tsd_pkg::MODULE_COUNT)) begin
			mod_limit = tsd_pkg::MODCNT_W'(tsd_pkg::MODULE_COUNT);
		end
		mem_bad = word_s1[31:24] >= 8'(tsd_pkg::MEMORY_COUNT);
		mod_bad = {1'b0, word_s1[23:16]} >= {4'b0, mod_limit};
		hdr_mod = mod_bad ? '0 : word_s1[16 +: tsd_pkg::MOD_W];
		hdr_mem = mem_bad ? '0 : word_s1[24 +: tsd_pkg::MEM_W];
	end

	// next state
	always_comb begin
		phase_n  = phase_e;
		mod_n    = mod_e;
		mem_n    = mem_e;
		exp_n    = exp_e;
		seen_n   = seen_e;
		halted_n = halt_e;
		if (halt_e) begin
			halted_n = 1'b1;
		end else if (!port_ok) begin
			halted_n = 1'b1;
		end else if (parse_hdr) begin
			seen_n = '0;
			if (hdr_ok) begin
				mod_n   = hdr_mod;
				mem_n   = hdr_mem;
				phase_n = tsd_pkg::PH_SIZE;
			end else begin
				halted_n = 1'b1;
				phase_n  = tsd_pkg::PH_HEADER;
			end
		end else if (phase_e == tsd_pkg::PH_SIZE) begin
			if (word_s1 == '0) begin
				phase_n = tsd_pkg::PH_ENDED;
			end else begin
				// negative byte count gives no data words
				exp_n   = word_s1[31] ? '0 : word_s1[31:2];
				seen_n  = '0;
				phase_n = tsd_pkg::PH_DATA;
			end
		end else if (phase_e == tsd_pkg::PH_DATA) begin
			seen_n = seen_e + tsd_pkg::CNT_W'(1);
		end
	end

	// result status
	always_comb begin
		status_c = tsd_pkg::ST_IGNORED;
		if (halt_e) begin
			status_c = tsd_pkg::ST_IGNORED;
		end else if (!port_ok) begin
			status_c = tsd_pkg::ST_BAD_PORT;
		end else if (parse_hdr) begin
			if (!hdr_ok) begin
				status_c = tsd_pkg::ST_BAD_HEADER;
			end else if (mod_bad || mem_bad) begin
				status_c = tsd_pkg::ST_CLAMPED;
			end else begin
				status_c = tsd_pkg::ST_FRAMING;
			end
		end else if (phase_e == tsd_pkg::PH_SIZE) begin
			status_c = (word_s1 == '0) ? tsd_pkg::ST_ZERO_SIZE : tsd_pkg::ST_FRAMING;
		end else if (phase_e == tsd_pkg::PH_DATA) begin
			status_c = tsd_pkg::ST_DATA;
		end
	end

	always_comb begin
		res.status     = status_c;
		res.data_word  = (status_c == tsd_pkg::ST_DATA) ? word_s1 : '0;
		res.port_tag   = port_s1[tsd_pkg::PORT_W-1:0];
		res.module_tag = mod_n;
		res.memory_tag = mem_n;
	end

	assign res_valid = adv;

	// state update once the result is handed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= tsd_pkg::PH_HEADER;
			mod_q    <= '0;
			mem_q    <= '0;
			exp_q    <= '0;
			seen_q   <= '0;
			halted_q <= 1'b0;
		end else if (adv) begin
			phase_q  <= phase_n;
			mod_q    <= mod_n;
			mem_q    <= mem_n;
			exp_q    <= exp_n;
			seen_q   <= seen_n;
			halted_q <= halted_n;
		end
	end

endmodule

[rtl/tsd_out_fifo.sv]
module tsd_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	input  tsd_pkg::result_t wr_data,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output tsd_pkg::result_t rd_data
);

	tsd_pkg::result_t entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             pop;

	assign out_valid = count_q != 2'd0;
	assign room      = count_q != 2'd2;
	assign pop       = out_valid && out_ready;
	assign rd_data   = entry_q[rd_ptr_q];

	// two-entry result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_valid) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (wr_valid && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !wr_valid) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_valid) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

[rtl/token_stream_deframer_unit.sv]
// channel   direction  handshake               payload
// input     in         in_valid / in_ready     word_in, port_in, subevent_start, event_start
// result    out        out_valid / out_ready   status, data_word, port_tag, module_tag, memory_tag
// config    in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one word per cycle sustained while the result side keeps up; a result passes the input register,
// then is parsed into the two-entry result buffer, from which it is offered on the output
// parser state updates only when a parsed word moves into the result buffer
// arst_n clears the parser to expect a header and loads the default module counts
// with the result side stalled two results are held, then in_ready drops after one more word
// cfg_ready is always high; writes take effect on the next cycle
module token_stream_deframer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [tsd_pkg::WORD_W-1:0]        word_in,
	input  logic [tsd_pkg::PORT_IN_W-1:0]     port_in,
	input  logic                              subevent_start,
	input  logic                              event_start,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        status,
	output logic [tsd_pkg::WORD_W-1:0]        data_word,
	output logic [tsd_pkg::PORT_W-1:0]        port_tag,
	output logic [tsd_pkg::MOD_W-1:0]         module_tag,
	output logic [tsd_pkg::MEM_W-1:0]         memory_tag,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tsd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tsd_pkg::MODCNT_W-1:0]      cfg_data
);

	tsd_pkg::modcnt_arr_t modcnt;
	tsd_pkg::result_t     res;
	tsd_pkg::result_t     head;
	logic                 res_valid;
	logic                 res_room;

	// module count registers
	tsd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.modcnt    (modcnt)
	);

	// framing parser
	tsd_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.word_in        (word_in),
		.port_in        (port_in),
		.subevent_start (subevent_start),
		.event_start    (event_start),
		.modcnt         (modcnt),
		.res_room       (res_room),
		.res_valid      (res_valid),
		.res            (res)
	);

	// result buffer
	tsd_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_valid  (res_valid),
		.wr_data   (res),
		.room      (res_room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rd_data   (head)
	);

	assign status     = head.status;
	assign data_word  = head.data_word;
	assign port_tag   = head.port_tag;
	assign module_tag = head.module_tag;
	assign memory_tag = head.memory_tag;

endmodule
